@@ src/swdr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swdr_pkg
// Shared widths, operation codes and the command and status groups that pass
// between the controller and the datapath of the detrended RMS core.
// ----------------------------------------------------------------------------
package swdr_pkg;

	localparam int EW         = 48;        // profile width
	localparam int HW         = EW / 2;    // half of the profile width
	localparam int SAMPLE_W   = 16;
	localparam int WL_W       = 11;
	localparam int WL_RESET   = 16;
	localparam int WL_MIN     = 3;
	localparam int FRAC_SHIFT = 32;        // two times the 16 fraction bits
	localparam int QW         = 2 * EW + FRAC_SHIFT;
	localparam int RMS_W      = 48;
	localparam int WS_W       = 32;

	// Steps of the closing multiply sequence, in the order they run.
	typedef enum logic [3:0] {
		OP_NSXX = 4'd0,  // n * Sxx
		OP_SXSX = 4'd1,  // Sx * Sx, gives the fit denominator
		OP_NSEE = 4'd2,  // n * See
		OP_SESE = 4'd3,  // Se * Se, gives Syy
		OP_NSXE = 4'd4,  // n * Sxe
		OP_SXSE = 4'd5,  // Sx * Se, gives |Sxy|
		OP_SYDD = 4'd6,  // Syy * D
		OP_SXY2 = 4'd7,  // Sxy * Sxy, gives the numerator
		OP_NN   = 4'd8,  // n * n
		OP_DEN  = 4'd9   // n^2 * D
	} op_t;

	typedef struct packed {
		logic accept;
		logic pass_start;
		logic mul_start;
		op_t  op;
		logic div_start;
		logic sqrt_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic win_ok;
		logic pass_done;
		logic mul_done;
		logic div_done;
		logic sqrt_done;
	} status_t;

endpackage

@@ src/swdr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swdr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module swdr_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/swdr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swdr_ctrl
// Sequencer: takes an item and, if its window is full, runs the window pass,
// the multiply chain, division and square root, then loads the output register.
// ----------------------------------------------------------------------------
module swdr_ctrl
	import swdr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  logic    m_tready,
	output logic    m_tvalid,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_CHECK = 10'b00_0000_0010,
		S_PASS  = 10'b00_0000_0100,
		S_MGO   = 10'b00_0000_1000,
		S_MUL   = 10'b00_0001_0000,
		S_DGO   = 10'b00_0010_0000,
		S_DIV   = 10'b00_0100_0000,
		S_SGO   = 10'b00_1000_0000,
		S_SQRT  = 10'b01_0000_0000,
		S_OUT   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	op_t    op_q, op_d;
	logic   out_valid_q;

	function automatic op_t next_op(input op_t op);
		op_t r;
		unique case (op)
			OP_NSXX: r = OP_SXSX;
			OP_SXSX: r = OP_NSEE;
			OP_NSEE: r = OP_SESE;
			OP_SESE: r = OP_NSXE;
			OP_NSXE: r = OP_SXSE;
			OP_SXSE: r = OP_SYDD;
			OP_SYDD: r = OP_SXY2;
			OP_SXY2: r = OP_NN;
			OP_NN:   r = OP_DEN;
			default: r = OP_DEN;
		endcase
		return r;
	endfunction

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		cmd     = '0;
		cmd.op  = op_q;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.win_ok) begin
					cmd.pass_start = 1'b1;
					op_d           = OP_NSXX;
					state_d        = S_PASS;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_PASS: begin
				if (st.pass_done) begin
					state_d = S_MGO;
				end
			end
			S_MGO: begin
				cmd.mul_start = 1'b1;
				state_d       = S_MUL;
			end
			S_MUL: begin
				if (st.mul_done) begin
					if (op_q == OP_DEN) begin
						state_d = S_DGO;
					end else begin
						op_d    = next_op(op_q);
						state_d = S_MGO;
					end
				end
			end
			S_DGO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (st.div_done) begin
					state_d = S_SGO;
				end
			end
			S_SGO: begin
				cmd.sqrt_start = 1'b1;
				state_d        = S_SQRT;
			end
			S_SQRT: begin
				if (st.sqrt_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_NSXX;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

@@ src/swdr_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swdr_dpath
// Datapath: profile update and store, window accumulation pipeline, shared
// shift-add multiplier, restoring divider, bit-pair square root, result hold.
// ----------------------------------------------------------------------------
module swdr_dpath
	import swdr_pkg::*;
#(
	parameter int WINDOW_MAX = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output status_t                    st,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       restart,
	input  logic                       cfg_we,
	input  logic [WL_W-1:0]            cfg_data,
	output logic [RMS_W-1:0]           rms,
	output logic [WS_W-1:0]            window_start
);

	localparam int NW   = $clog2(WINDOW_MAX + 1);
	localparam int JW   = $clog2(WINDOW_MAX);
	localparam int SEW  = EW + 1 + NW;
	localparam int SXEW = EW + 1 + JW + NW;
	localparam int SEEW = 2 * EW + NW;
	localparam int SXW  = 2 * NW;
	localparam int SXXW = 3 * NW;
	localparam int JEW  = JW + EW;
	localparam int PW   = 2 * EW + 6 * NW;
	localparam int DVW  = PW + FRAC_SHIFT;
	localparam int DCW  = $clog2(DVW);
	localparam int SCW  = $clog2(QW / 2);
	localparam logic [NW:0]   WM_X  = (NW + 1)'(WINDOW_MAX);
	localparam logic [JW-1:0] PTR_LAST = JW'(WINDOW_MAX - 1);

	// ---------------- item side: profile, pointers, counters ----------------
	logic signed [EW-1:0] prof_q, prof_cur, p_new;
	logic signed [EW:0]   p_sum;
	logic [JW-1:0]        ptr_q, ptr_cur, ptr_nxt;
	logic [NW-1:0]        fill_q, fill_cur, fill_nxt;
	logic [WS_W-1:0]      seen_q, seen_nxt;
	logic [WL_W-1:0]      wl_q;
	logic [31:0]          n_wide;
	logic [NW-1:0]        n_eff, n_q;
	logic [NW:0]          f_sum, f_wrap;
	logic [JW-1:0]        first_q;
	logic [WS_W-1:0]      ws_q;
	logic                 win_ok_q;

	assign prof_cur = restart ? '0 : prof_q;
	assign ptr_cur  = restart ? '0 : ptr_q;
	assign fill_cur = restart ? '0 : fill_q;
	assign p_sum    = (EW + 1)'(prof_cur) + (EW + 1)'(sample);
	assign p_new    = (p_sum[EW] != p_sum[EW-1])
		? (p_sum[EW] ? {1'b1, {(EW - 1){1'b0}}} : {1'b0, {(EW - 1){1'b1}}})
		: p_sum[EW-1:0];
	assign ptr_nxt  = (ptr_cur == PTR_LAST) ? '0 : ptr_cur + JW'(1);
	assign fill_nxt = (fill_cur < NW'(WINDOW_MAX)) ? fill_cur + NW'(1) : fill_cur;
	assign seen_nxt = (restart ? '0 : seen_q) + WS_W'(1);

	always_comb begin
		if (32'(wl_q) < 32'(WL_MIN)) begin
			n_wide = 32'(WL_MIN);
		end else if (32'(wl_q) > 32'(WINDOW_MAX)) begin
			n_wide = 32'(WINDOW_MAX);
		end else begin
			n_wide = 32'(wl_q);
		end
	end
	assign n_eff  = n_wide[NW-1:0];
	assign f_sum  = (NW + 1)'(ptr_nxt) + WM_X - (NW + 1)'(n_eff);
	assign f_wrap = (f_sum >= WM_X) ? f_sum - WM_X : f_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prof_q   <= '0;
			ptr_q    <= '0;
			fill_q   <= '0;
			seen_q   <= '0;
			wl_q     <= WL_W'(WL_RESET);
			win_ok_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				wl_q <= cfg_data;
			end
			if (cmd.accept) begin
				prof_q   <= p_new;
				ptr_q    <= ptr_nxt;
				fill_q   <= fill_nxt;
				seen_q   <= seen_nxt;
				win_ok_q <= (fill_nxt >= n_eff);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			n_q     <= n_eff;
			first_q <= f_wrap[JW-1:0];
			ws_q    <= seen_nxt - WS_W'(n_eff);
		end
	end

	// ---------------- profile store ----------------
	logic                 rd_en;
	logic [JW-1:0]        addr_q;
	logic signed [EW-1:0] rdata;

	swdr_ram #(
		.WIDTH(EW),
		.DEPTH(WINDOW_MAX)
	) u_store (
		.clk  (clk),
		.we   (cmd.accept),
		.waddr(ptr_cur),
		.wdata(p_new),
		.re   (rd_en),
		.raddr(addr_q),
		.rdata(rdata)
	);

	// ---------------- window pass ----------------
	logic                   pass_q, issuing_q;
	logic [JW-1:0]          j_q, j_s1, j_s2, j_s3;
	logic                   v_s1, v_s2, v_s3;
	logic signed [EW-1:0]   base_q, base_sel;
	logic signed [EW:0]     e_s1, e_s2, e_s3, e_abs;
	logic [EW-1:0]          mag;
	logic [2*HW-1:0]        hh_s3, hl_s3, ll_s3;
	logic [JEW-1:0]         je_s3;
	logic [2*JW-1:0]        jj_s3;
	logic                   neg_s3;
	logic signed [SEW-1:0]  se_q;
	logic signed [SXEW-1:0] sxe_q, je_x;
	logic [SEEW-1:0]        see_q, ee;
	logic [SXW-1:0]         sx_q;
	logic [SXXW-1:0]        sxx_q;

	assign rd_en    = issuing_q;
	assign base_sel = (j_s1 == '0) ? rdata : base_q;
	assign e_s1     = (EW + 1)'(rdata) - (EW + 1)'(base_sel);
	assign e_abs    = e_s2[EW] ? -e_s2 : e_s2;
	assign mag      = e_abs[EW-1:0];
	assign ee       = (SEEW'(hh_s3) << (2 * HW)) + (SEEW'(hl_s3) << (HW + 1)) + SEEW'(ll_s3);
	assign je_x     = SXEW'(je_s3);

	assign st.pass_done = pass_q && !issuing_q && !v_s1 && !v_s2 && !v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q    <= 1'b0;
			issuing_q <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
		end else begin
			v_s1 <= issuing_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.pass_start) begin
				pass_q    <= 1'b1;
				issuing_q <= 1'b1;
			end else begin
				if (st.pass_done) begin
					pass_q <= 1'b0;
				end
				if (issuing_q && (NW'(j_q) == n_q - NW'(1))) begin
					issuing_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pass_start) begin
			addr_q <= first_q;
			j_q    <= '0;
			se_q   <= '0;
			sxe_q  <= '0;
			see_q  <= '0;
			sx_q   <= '0;
			sxx_q  <= '0;
		end else begin
			if (issuing_q) begin
				addr_q <= (addr_q == PTR_LAST) ? '0 : addr_q + JW'(1);
				j_q    <= j_q + JW'(1);
			end
			if (v_s3) begin
				se_q  <= se_q + SEW'(e_s3);
				sxe_q <= neg_s3 ? sxe_q - je_x : sxe_q + je_x;
				see_q <= see_q + ee;
				sx_q  <= sx_q + SXW'(j_s3);
				sxx_q <= sxx_q + SXXW'(jj_s3);
			end
		end
		j_s1 <= j_q;
		if (v_s1 && (j_s1 == '0)) begin
			base_q <= rdata;
		end
		e_s2   <= e_s1;
		j_s2   <= j_s1;
		e_s3   <= e_s2;
		j_s3   <= j_s2;
		neg_s3 <= e_s2[EW];
		hh_s3  <= mag[EW-1:HW] * mag[EW-1:HW];
		hl_s3  <= mag[EW-1:HW] * mag[HW-1:0];
		ll_s3  <= mag[HW-1:0] * mag[HW-1:0];
		je_s3  <= JEW'(j_s2) * JEW'(mag);
		jj_s3  <= (2 * JW)'(j_s2) * (2 * JW)'(j_s2);
	end

	// ---------------- multiply chain ----------------
	logic [SEW-1:0]         se_abs;
	logic [SXEW-1:0]        sxe_abs;
	logic [PW-1:0]          a_in, b_in;
	logic [PW-1:0]          mul_a_q, mul_b_q, acc_q;
	logic                   mul_busy_q;
	logic [PW-1:0]          t_q, dd_q, syy_q, sxy_q, num_q, den_q, sxy_new;
	logic                   tneg_q;
	logic signed [PW+1:0]   t_x, p_x, v1, v2, d_x;

	assign se_abs  = se_q[SEW-1] ? SEW'(-se_q) : SEW'(se_q);
	assign sxe_abs = sxe_q[SXEW-1] ? SXEW'(-sxe_q) : SXEW'(sxe_q);

	always_comb begin
		unique case (cmd.op)
			OP_NSXX: begin a_in = PW'(sxx_q);   b_in = PW'(n_q);    end
			OP_SXSX: begin a_in = PW'(sx_q);    b_in = PW'(sx_q);   end
			OP_NSEE: begin a_in = PW'(see_q);   b_in = PW'(n_q);    end
			OP_SESE: begin a_in = PW'(se_abs);  b_in = PW'(se_abs); end
			OP_NSXE: begin a_in = PW'(sxe_abs); b_in = PW'(n_q);    end
			OP_SXSE: begin a_in = PW'(se_abs);  b_in = PW'(sx_q);   end
			OP_SYDD: begin a_in = syy_q;        b_in = dd_q;        end
			OP_SXY2: begin a_in = sxy_q;        b_in = sxy_q;       end
			OP_NN:   begin a_in = PW'(n_q);     b_in = PW'(n_q);    end
			OP_DEN:  begin a_in = dd_q;         b_in = den_q;       end
			default: begin a_in = '0;           b_in = '0;          end
		endcase
	end

	assign st.mul_done = mul_busy_q && (mul_b_q == '0);

	// Signed difference for the cross term, then its magnitude.
	assign t_x     = (PW + 2)'(t_q);
	assign p_x     = (PW + 2)'(acc_q);
	assign v1      = tneg_q ? -t_x : t_x;
	assign v2      = se_q[SEW-1] ? -p_x : p_x;
	assign d_x     = v1 - v2;
	assign sxy_new = d_x[PW+1] ? PW'(-d_x) : PW'(d_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
		end else if (cmd.mul_start) begin
			mul_busy_q <= 1'b1;
		end else if (st.mul_done) begin
			mul_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mul_a_q <= a_in;
			mul_b_q <= b_in;
			acc_q   <= '0;
		end else if (mul_busy_q && (mul_b_q != '0)) begin
			if (mul_b_q[0]) begin
				acc_q <= acc_q + mul_a_q;
			end
			mul_a_q <= mul_a_q << 1;
			mul_b_q <= mul_b_q >> 1;
		end
		if (st.mul_done) begin
			unique case (cmd.op)
				OP_NSXX: t_q   <= acc_q;
				OP_SXSX: dd_q  <= t_q - acc_q;
				OP_NSEE: t_q   <= acc_q;
				OP_SESE: syy_q <= t_q - acc_q;
				OP_NSXE: begin
					t_q    <= acc_q;
					tneg_q <= sxe_q[SXEW-1];
				end
				OP_SXSE: sxy_q <= sxy_new;
				OP_SYDD: t_q   <= acc_q;
				OP_SXY2: num_q <= (t_q >= acc_q) ? t_q - acc_q : '0;
				OP_NN:   den_q <= acc_q;
				OP_DEN:  den_q <= acc_q;
				default: t_q   <= t_q;
			endcase
		end
	end

	// ---------------- restoring divider ----------------
	logic [DVW-1:0] dvd_q;
	logic [PW-1:0]  rem_q;
	logic [QW-1:0]  quo_q;
	logic [DCW-1:0] dcnt_q;
	logic           div_busy_q;
	logic [PW:0]    r2, r2_diff;
	logic           r2_ge;

	assign r2      = {rem_q, dvd_q[DVW-1]};
	assign r2_ge   = (r2 >= {1'b0, den_q});
	assign r2_diff = r2 - {1'b0, den_q};
	assign st.div_done = div_busy_q && (dcnt_q == DCW'(DVW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
		end else if (st.div_done) begin
			div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q  <= {num_q, {FRAC_SHIFT{1'b0}}};
			rem_q  <= '0;
			quo_q  <= '0;
			dcnt_q <= '0;
		end else if (div_busy_q) begin
			rem_q  <= r2_ge ? r2_diff[PW-1:0] : r2[PW-1:0];
			dvd_q  <= dvd_q << 1;
			quo_q  <= {quo_q[QW-2:0], r2_ge};
			dcnt_q <= dcnt_q + DCW'(1);
		end
	end

	// ---------------- square root ----------------
	logic [QW-1:0]  x_q, res_q, one_q, sq_t;
	logic [SCW-1:0] scnt_q;
	logic           sq_busy_q;
	logic           sq_ge;

	assign sq_t  = res_q + one_q;
	assign sq_ge = (x_q >= sq_t);
	assign st.sqrt_done = sq_busy_q && (scnt_q == SCW'(QW / 2 - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
		end else if (cmd.sqrt_start) begin
			sq_busy_q <= 1'b1;
		end else if (st.sqrt_done) begin
			sq_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			x_q    <= quo_q;
			res_q  <= '0;
			one_q  <= {2'b01, {(QW - 2){1'b0}}};
			scnt_q <= '0;
		end else if (sq_busy_q) begin
			if (sq_ge) begin
				x_q   <= x_q - sq_t;
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q  <= one_q >> 2;
			scnt_q <= scnt_q + SCW'(1);
		end
	end

	// ---------------- result hold ----------------
	logic [RMS_W-1:0] rms_q;
	logic [WS_W-1:0]  ws_out_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rms_q    <= res_q[RMS_W-1:0];
			ws_out_q <= ws_q;
		end
	end

	assign st.win_ok     = win_ok_q;
	assign rms           = rms_q;
	assign window_start  = ws_out_q;

endmodule

@@ src/sliding_window_detrended_rms_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_detrended_rms_core
// First-order detrended fluctuation over a sliding window of profile values.
// ----------------------------------------------------------------------------
// Each accepted item adds its sample to a saturating running sum (the
// profile) and stores it. Once at least window_length profile values exist
// since the last restart, the block fits a least-squares line to the newest
// window and delivers the root mean square of the residuals with 16 fraction
// bits, plus the index of the window's first sample. The block works on one
// item at a time. An item that yields a result runs the window pass (one
// store read per cycle), then the multiply chain (ten shift-add products),
// the restoring divider and the square root, and then loads the output
// register. The next item is taken while a finished result still waits in
// the output register. The profile store is not cleared after reset; the
// fill count keeps unread entries out of a window.
// ----------------------------------------------------------------------------
module sliding_window_detrended_rms_core
	import swdr_pkg::*;
#(
	parameter int WINDOW_MAX = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input items.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample (signed)
	input  logic        s_tuser,   // [0] restart
	// Result items.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [47:0] rms, [79:48] window_start
	// Window length register.
	input  logic        cfg_we,
	input  logic [10:0] cfg_data
);

	cmd_t             cmd;
	status_t          st;
	logic [RMS_W-1:0] rms;
	logic [WS_W-1:0]  window_start;

	// The controller only sequences; every register of the arithmetic sits in
	// the datapath.
	swdr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.st      (st),
		.cmd     (cmd)
	);

	swdr_dpath #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.sample      (s_tdata),
		.restart     (s_tuser),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.rms         (rms),
		.window_start(window_start)
	);

	assign m_tdata = {window_start, rms};

	// An accepted item always keeps the block busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted twice in a row");

	// A new result only appears when the input was not ready just before it.
	a_result_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result raised while idle");

	// The arithmetic units never finish in the same cycle.
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({st.pass_done, st.mul_done, st.div_done, st.sqrt_done}))
		else $error("two units finished together");

endmodule
